>>> design/lphs_pkg.sv
`default_nettype none
package lphs_pkg;

	localparam int unsigned CAPACITY   = 1024;
	localparam int unsigned ADDR_W     = $clog2(CAPACITY);
	localparam int unsigned KEY_WIDTH  = 32;
	localparam int unsigned COUNT_W    = 10;
	localparam int unsigned FILL_RESET = 768;

	typedef logic [ADDR_W-1:0]    addr_t;
	typedef logic [KEY_WIDTH-1:0] key_t;
	typedef logic [COUNT_W-1:0]   count_t;

	localparam logic [1:0] ACT_INSERT = 2'd0;
	localparam logic [1:0] ACT_DELETE = 2'd1;
	localparam logic [1:0] ACT_LOOKUP = 2'd2;
	localparam logic [1:0] ACT_UNUSED = 2'd3;

	typedef enum logic [2:0] {
		STAT_INSERTED  = 3'd0,
		STAT_DUPLICATE = 3'd1,
		STAT_FULL      = 3'd2,
		STAT_DELETED   = 3'd3,
		STAT_ABSENT    = 3'd4,
		STAT_PRESENT   = 3'd5,
		STAT_INVALID   = 3'd6
	} status_t;

	// True when an entry with home h sitting at cur must stay behind the gap.
	function automatic logic keeps_home(input addr_t gap, input addr_t cur, input addr_t h);
		logic r;
		if (gap <= cur) begin
			r = (gap < h) && (h <= cur);
		end else begin
			r = (gap < h) || (h <= cur);
		end
		return r;
	endfunction

endpackage
`default_nettype wire

>>> design/linear_probe_hash_set_core.sv
// An invalid request (zero key or unused action) is answered in the cycle after start.
// Insert and lookup probe slot by slot from the home slot until a hit or an empty slot.
// Delete probes the same way, then walks the chain after the hit, shifting entries back into the gap.
// One table read per cycle sets the pace; one request is in flight at a time (busy).
// After reset a clearing pass zeroes all 1024 slots with busy high.
// Results are strobed on done for one cycle; the receiver cannot stall.
`default_nettype none
module linear_probe_hash_set_core (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               start,
	output logic                                    busy,
	input  wire logic [1:0]                         action,
	input  wire logic [lphs_pkg::KEY_WIDTH-1:0]     key,
	input  wire logic                               cfg_valid,
	output logic                                    cfg_ready,
	input  wire logic [lphs_pkg::COUNT_W-1:0]       cfg_data,
	output logic                                    done,
	output logic [2:0]                              status,
	output logic [lphs_pkg::COUNT_W-1:0]            entry_count
);

	typedef enum logic [1:0] {
		S_CLEAR,
		S_IDLE,
		S_PROBE,
		S_SHIFT
	} state_t;

	state_t                state_q;
	lphs_pkg::addr_t       ptr_q;
	lphs_pkg::addr_t       gap_q;
	lphs_pkg::key_t        key_q;
	logic [1:0]            act_q;
	lphs_pkg::count_t      held_q;
	lphs_pkg::count_t      limit_q;
	lphs_pkg::status_t     status_q;
	logic                  done_q;

	lphs_pkg::key_t        mem [lphs_pkg::CAPACITY];
	lphs_pkg::key_t        rd_data_q;
	lphs_pkg::addr_t       rd_addr;
	logic                  wr_en;
	lphs_pkg::addr_t       wr_addr;
	lphs_pkg::key_t        wr_data;

	lphs_pkg::addr_t       ptr_next;
	logic                  hit;
	logic                  empty;
	logic                  stays;
	logic                  room;

	assign ptr_next = ptr_q + lphs_pkg::addr_t'(1);
	assign hit      = (rd_data_q == key_q);
	assign empty    = (rd_data_q == '0);
	assign stays    = lphs_pkg::keeps_home(gap_q, ptr_q, rd_data_q[lphs_pkg::ADDR_W-1:0]);
	assign room     = (held_q < limit_q);

	assign busy        = (state_q != S_IDLE);
	assign cfg_ready   = 1'b1;
	assign done        = done_q;
	assign status      = status_q;
	assign entry_count = held_q;

	// Read one slot ahead of the slot being examined; while idle, read the incoming key's home slot.
	always_comb begin
		rd_addr = ptr_next;
		if (state_q == S_IDLE) begin
			rd_addr = key[lphs_pkg::ADDR_W-1:0];
		end
	end

	always_comb begin
		wr_en   = 1'b0;
		wr_addr = ptr_q;
		wr_data = key_q;
		unique case (state_q)
			S_CLEAR: begin
				wr_en   = 1'b1;
				wr_data = '0;
			end
			S_PROBE: begin
				if (!hit && empty && act_q == lphs_pkg::ACT_INSERT && room) begin
					wr_en = 1'b1;
				end
			end
			S_SHIFT: begin
				wr_addr = gap_q;
				if (empty) begin
					wr_en   = 1'b1;
					wr_data = '0;
				end else if (!stays) begin
					wr_en   = 1'b1;
					wr_data = rd_data_q;
				end
			end
			S_IDLE: begin
				wr_en = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_data_q <= mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_CLEAR;
			ptr_q    <= '0;
			gap_q    <= '0;
			key_q    <= '0;
			act_q    <= lphs_pkg::ACT_INSERT;
			held_q   <= '0;
			limit_q  <= lphs_pkg::count_t'(lphs_pkg::FILL_RESET);
			status_q <= lphs_pkg::STAT_INVALID;
			done_q   <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (cfg_valid) begin
				limit_q <= cfg_data;
			end
			unique case (state_q)
				S_CLEAR: begin
					ptr_q <= ptr_next;
					if (ptr_q == lphs_pkg::addr_t'(lphs_pkg::CAPACITY - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (start) begin
						key_q <= key;
						act_q <= action;
						ptr_q <= key[lphs_pkg::ADDR_W-1:0];
						if (key == '0 || action == lphs_pkg::ACT_UNUSED) begin
							done_q   <= 1'b1;
							status_q <= lphs_pkg::STAT_INVALID;
						end else begin
							state_q <= S_PROBE;
						end
					end
				end
				S_PROBE: begin
					priority if (hit) begin
						priority case (act_q)
							lphs_pkg::ACT_INSERT: begin
								status_q <= lphs_pkg::STAT_DUPLICATE;
								done_q   <= 1'b1;
								state_q  <= S_IDLE;
							end
							lphs_pkg::ACT_DELETE: begin
								// open the gap here, walk the chain behind it
								gap_q   <= ptr_q;
								ptr_q   <= ptr_next;
								state_q <= S_SHIFT;
							end
							default: begin
								status_q <= lphs_pkg::STAT_PRESENT;
								done_q   <= 1'b1;
								state_q  <= S_IDLE;
							end
						endcase
					end else if (empty) begin
						if (act_q == lphs_pkg::ACT_INSERT) begin
							if (room) begin
								held_q   <= held_q + lphs_pkg::count_t'(1);
								status_q <= lphs_pkg::STAT_INSERTED;
							end else begin
								status_q <= lphs_pkg::STAT_FULL;
							end
						end else begin
							status_q <= lphs_pkg::STAT_ABSENT;
						end
						done_q  <= 1'b1;
						state_q <= S_IDLE;
					end else begin
						ptr_q <= ptr_next;
					end
				end
				S_SHIFT: begin
					if (empty) begin
						held_q   <= held_q - lphs_pkg::count_t'(1);
						status_q <= lphs_pkg::STAT_DELETED;
						done_q   <= 1'b1;
						state_q  <= S_IDLE;
					end else begin
						if (!stays) begin
							gap_q <= ptr_q;
						end
						ptr_q <= ptr_next;
					end
				end
			endcase
		end
	end

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy) else $error("result strobed while busy");

	a_count_moves_on_done: assert property (@(posedge clk) disable iff (!arst_n)
		!$stable(entry_count) |-> done) else $error("count changed without a result");

	a_insert_count: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status == lphs_pkg::STAT_INSERTED) |->
		entry_count == $past(entry_count) + lphs_pkg::count_t'(1))
		else $error("insert did not bump the count");

	a_delete_count: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status == lphs_pkg::STAT_DELETED) |->
		entry_count == $past(entry_count) - lphs_pkg::count_t'(1))
		else $error("delete did not drop the count");

	a_no_write_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE) |-> !wr_en) else $error("table written while idle");

endmodule
`default_nettype wire
